[design/rpcf_pkg.sv]
// Package: shared types, constants and byte selection for the raster print command framer.
`timescale 1ns / 1ps
`default_nettype none

package rpcf_pkg;

  // Lines per GS v 0 raster block.
  localparam int unsigned LINES_PER_BLOCK = 240;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LINES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINT_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRINT_DENS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIA_TYPE   = 3'd4;

  // Command bytes.
  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_GS       = 8'h1D;
  localparam logic [7:0] BYTE_US       = 8'h1F;
  localparam logic [7:0] BYTE_N        = 8'h4E;
  localparam logic [7:0] BYTE_SPEED    = 8'h0D;
  localparam logic [7:0] BYTE_DENSITY  = 8'h04;
  localparam logic [7:0] BYTE_MEDIA    = 8'h11;
  localparam logic [7:0] BYTE_V        = 8'h76;
  localparam logic [7:0] BYTE_ZERO_CH  = 8'h30;
  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_END_CMD  = 8'hF0;
  localparam logic [7:0] BYTE_END_A    = 8'h05;
  localparam logic [7:0] BYTE_END_B    = 8'h03;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_LF_SUB   = 8'h14;

  // Positions in the full per-transaction byte sequence.
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_PROLOGUE = 5'd0;
  localparam logic [POS_W-1:0] POS_SPEED    = 5'd3;
  localparam logic [POS_W-1:0] POS_DENSITY  = 5'd7;
  localparam logic [POS_W-1:0] POS_MEDIA    = 5'd10;
  localparam logic [POS_W-1:0] POS_HEADER   = 5'd11;
  localparam logic [POS_W-1:0] POS_WIDTH_L  = 5'd15;
  localparam logic [POS_W-1:0] POS_WIDTH_H  = 5'd16;
  localparam logic [POS_W-1:0] POS_BLK_L    = 5'd17;
  localparam logic [POS_W-1:0] POS_BLK_H    = 5'd18;
  localparam logic [POS_W-1:0] POS_DATA     = 5'd19;
  localparam logic [POS_W-1:0] POS_TRAILER  = 5'd20;
  localparam logic [POS_W-1:0] POS_LAST     = 5'd27;

  localparam int unsigned SEQ_LEN = 28;

  // Fixed bytes of the sequence; variable slots hold zero and are overridden.
  localparam logic [7:0] CMD_TEMPLATE [SEQ_LEN] = '{
    BYTE_ESC, BYTE_N, BYTE_SPEED, BYTE_NUL,
    BYTE_ESC, BYTE_N, BYTE_DENSITY, BYTE_NUL,
    BYTE_US, BYTE_MEDIA, BYTE_NUL,
    BYTE_GS, BYTE_V, BYTE_ZERO_CH, BYTE_NUL,
    BYTE_NUL, BYTE_NUL, BYTE_NUL, BYTE_NUL,
    BYTE_NUL,
    BYTE_US, BYTE_END_CMD, BYTE_END_A, BYTE_NUL,
    BYTE_US, BYTE_END_CMD, BYTE_END_B, BYTE_NUL
  };

  typedef struct packed {
    logic [15:0] line_width_bytes;
    logic [15:0] total_lines;
    logic [7:0]  print_speed;
    logic [7:0]  print_density;
    logic [7:0]  media_type;
  } cfg_t;

  // What the tracker decides for the transaction being accepted.
  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic             ended;
    logic [15:0]      blk_lines;
  } plan_t;

  function automatic logic [15:0] eff_width(input cfg_t cfg);
    eff_width = (cfg.line_width_bytes == 16'd0) ? 16'd1 : cfg.line_width_bytes;
  endfunction

  function automatic logic [7:0] seq_byte(input logic [POS_W-1:0] pos, input cfg_t cfg,
                                          input logic [7:0] px, input logic [15:0] blk);
    logic [15:0] w;
    w = eff_width(cfg);
    case (pos)
      POS_SPEED:   seq_byte = cfg.print_speed;
      POS_DENSITY: seq_byte = cfg.print_density;
      POS_MEDIA:   seq_byte = cfg.media_type;
      POS_WIDTH_L: seq_byte = w[7:0];
      POS_WIDTH_H: seq_byte = w[15:8];
      POS_BLK_L:   seq_byte = blk[7:0];
      POS_BLK_H:   seq_byte = blk[15:8];
      POS_DATA:    seq_byte = (px == BYTE_LF) ? BYTE_LF_SUB : px;
      default: begin
        if (pos <= POS_LAST) begin
          seq_byte = CMD_TEMPLATE[pos];
        end else begin
          seq_byte = BYTE_NUL;
        end
      end
    endcase
  endfunction

endpackage

`default_nettype wire

[design/rpcf_stream_if.sv]
// Interfaces: valid/ready channels for bitmap bytes in and command bytes out.
`timescale 1ns / 1ps
`default_nettype none

interface rpcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

interface rpcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       job_end;

  modport source (output valid, output out_byte, output last_of_run, output job_end,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input job_end,
                output ready);
endinterface

`default_nettype wire

[design/rpcf_tracker.sv]
// Job tracker: column, line and block counters that plan each accepted transaction.
`timescale 1ns / 1ps
`default_nettype none

module rpcf_tracker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rpcf_pkg::cfg_t cfg,
  input  wire logic           advance,
  output rpcf_pkg::plan_t     plan
);

  logic [15:0] column_count_r, column_count_nxt;
  logic [15:0] line_in_block_r, line_in_block_nxt;
  logic [15:0] lines_left_r, lines_left_nxt;
  logic        job_active_r, job_active_nxt;

  logic        start;
  logic [15:0] ll, lib, cc, w, ll_dec, lib_inc;
  logic        hdr, line_end, ended;

  always_comb begin
    start = !job_active_r;
    w     = rpcf_pkg::eff_width(cfg);
    if (start) begin
      ll  = (cfg.total_lines == 16'd0) ? 16'd1 : cfg.total_lines;
      lib = 16'd0;
      cc  = 16'd0;
    end else begin
      ll  = lines_left_r;
      lib = line_in_block_r;
      cc  = column_count_r;
    end
    hdr      = (cc == 16'd0) && (lib == 16'd0);
    line_end = ({1'b0, cc} + 17'd1) >= {1'b0, w};
    ll_dec   = (ll != 16'd0) ? ll - 16'd1 : 16'd0;
    ended    = line_end && (ll_dec == 16'd0);
    lib_inc  = lib + 16'd1;

    plan.ended = ended;
    if (start) begin
      plan.start_pos = rpcf_pkg::POS_PROLOGUE;
    end else if (hdr) begin
      plan.start_pos = rpcf_pkg::POS_HEADER;
    end else begin
      plan.start_pos = rpcf_pkg::POS_DATA;
    end
    if ({16'd0, ll} > rpcf_pkg::LINES_PER_BLOCK) begin
      plan.blk_lines = 16'(rpcf_pkg::LINES_PER_BLOCK);
    end else begin
      plan.blk_lines = ll;
    end

    if (line_end) begin
      column_count_nxt = 16'd0;
      lines_left_nxt   = ll_dec;
      if (ended || ({16'd0, lib_inc} >= rpcf_pkg::LINES_PER_BLOCK)) begin
        line_in_block_nxt = 16'd0;
      end else begin
        line_in_block_nxt = lib_inc;
      end
    end else begin
      column_count_nxt  = cc + 16'd1;
      lines_left_nxt    = ll;
      line_in_block_nxt = lib;
    end
    job_active_nxt = !ended;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r  <= 16'd0;
      line_in_block_r <= 16'd0;
      lines_left_r    <= 16'd0;
      job_active_r    <= 1'b0;
    end else if (advance) begin
      column_count_r  <= column_count_nxt;
      line_in_block_r <= line_in_block_nxt;
      lines_left_r    <= lines_left_nxt;
      job_active_r    <= job_active_nxt;
    end
  end

endmodule

`default_nettype wire

[design/raster_print_command_framer.sv]
// Top level: raster print command framer with configuration registers and byte emitter.
`timescale 1ns / 1ps
`default_nettype none

// Takes one bitmap byte per transaction and produces the printer command stream: an
// 11-byte prologue on the first byte of a job, an 8-byte GS v 0 header at the start of
// each block of lines, the data byte itself (0x0A sent as 0x14), and an 8-byte trailer
// after the last byte of the job. The emitter sends one byte per cycle while out_ch is
// ready. A new transaction is accepted in the cycle the previous one's final byte enters
// the output register, so plain data bytes stream at one per cycle while out_ch is ready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while idle, as the block itself does not enforce this.
module raster_print_command_framer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  rpcf_in_if.sink                               in_ch,
  rpcf_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [rpcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rpcf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rpcf_pkg::cfg_t  cfg_r;
  rpcf_pkg::plan_t plan;

  logic                       item_valid_r;
  logic [rpcf_pkg::POS_W-1:0] pos_r;
  logic                       ended_r;
  logic [15:0]                blk_r;
  logic [7:0]                 px_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       last_r;
  logic       job_end_r;

  logic accept, load, is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width_bytes <= 16'd1;
      cfg_r.total_lines      <= 16'd1;
      cfg_r.print_speed      <= 8'd0;
      cfg_r.print_density    <= 8'd0;
      cfg_r.media_type       <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpcf_pkg::CFG_LINE_WIDTH:  cfg_r.line_width_bytes <= cfg_data;
        rpcf_pkg::CFG_TOTAL_LINES: cfg_r.total_lines      <= cfg_data;
        rpcf_pkg::CFG_PRINT_SPEED: cfg_r.print_speed      <= cfg_data[7:0];
        rpcf_pkg::CFG_PRINT_DENS:  cfg_r.print_density    <= cfg_data[7:0];
        rpcf_pkg::CFG_MEDIA_TYPE:  cfg_r.media_type       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rpcf_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .advance (accept),
    .plan    (plan)
  );

  // The data byte ends the transaction unless the job ends with it.
  assign is_last = ((pos_r == rpcf_pkg::POS_DATA) && !ended_r) ||
                   (pos_r == rpcf_pkg::POS_LAST);
  assign load    = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || (load && is_last);
  assign accept  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      pos_r        <= rpcf_pkg::POS_PROLOGUE;
    end else if (accept) begin
      item_valid_r <= 1'b1;
      pos_r        <= plan.start_pos;
    end else if (load) begin
      if (is_last) begin
        item_valid_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ended_r <= plan.ended;
      blk_r   <= plan.blk_lines;
      px_r    <= in_ch.pixel_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= rpcf_pkg::seq_byte(pos_r, cfg_r, px_r, blk_r);
      last_r     <= is_last;
      job_end_r  <= (pos_r == rpcf_pkg::POS_LAST);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.job_end     = job_end_r;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench: drives bitmap bytes into the raster print command framer and checks its output.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET    = 450;
  localparam int unsigned IDLE_PCT       = 16;
  localparam int unsigned RUN_CAP        = 64;

  typedef struct packed {
    logic [7:0] data;
    logic       last_of_run;
    logic       job_end;
  } cmd_byte_t;

  class framer_scoreboard;
    rpcf_pkg::cfg_t regs;
    logic [15:0]    column_count;
    logic [15:0]    line_in_block;
    logic [15:0]    lines_left;
    bit             job_active;
    cmd_byte_t      stream_q[$];
    int unsigned    errors;

    function new();
      regs = '0;
      regs.line_width_bytes = 16'd1;
      regs.total_lines = 16'd1;
      column_count = '0;
      line_in_block = '0;
      lines_left = '0;
      job_active = 1'b0;
      errors = 0;
    endfunction

    function void apply_reg(logic [rpcf_pkg::CFG_IDX_W-1:0] idx,
                            logic [rpcf_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        rpcf_pkg::CFG_LINE_WIDTH:  regs.line_width_bytes = value;
        rpcf_pkg::CFG_TOTAL_LINES: regs.total_lines = value;
        rpcf_pkg::CFG_PRINT_SPEED: regs.print_speed = value[7:0];
        rpcf_pkg::CFG_PRINT_DENS:  regs.print_density = value[7:0];
        rpcf_pkg::CFG_MEDIA_TYPE:  regs.media_type = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned line_bytes();
      return (regs.line_width_bytes == 16'd0) ? 1 : int'(regs.line_width_bytes);
    endfunction

    // Number of further bytes that would close the current job, or a fresh one.
    function int unsigned bytes_to_job_end();
      int unsigned w;
      w = line_bytes();
      if (!job_active) begin
        return w * ((regs.total_lines == 16'd0) ? 1 : int'(regs.total_lines));
      end
      if (int'(column_count) + 1 >= w) begin
        return (int'(lines_left) - 1) * w + 1;
      end
      return int'(lines_left) * w - int'(column_count);
    endfunction

    function void emit(logic [7:0] b);
      stream_q.push_back({b, 2'b00});
    endfunction

    function void note_pixel(logic [7:0] px);
      logic [15:0] width;
      logic [15:0] blk;
      bit          ended;
      cmd_byte_t   tail;
      width = 16'(line_bytes());
      ended = 1'b0;
      if (!job_active) begin
        emit(rpcf_pkg::BYTE_ESC); emit(rpcf_pkg::BYTE_N);
        emit(rpcf_pkg::BYTE_SPEED); emit(regs.print_speed);
        emit(rpcf_pkg::BYTE_ESC); emit(rpcf_pkg::BYTE_N);
        emit(rpcf_pkg::BYTE_DENSITY); emit(regs.print_density);
        emit(rpcf_pkg::BYTE_US); emit(rpcf_pkg::BYTE_MEDIA); emit(regs.media_type);
        lines_left = (regs.total_lines == 16'd0) ? 16'd1 : regs.total_lines;
        line_in_block = '0;
        column_count = '0;
        job_active = 1'b1;
      end
      if (column_count == 16'd0 && line_in_block == 16'd0) begin
        blk = (lines_left > rpcf_pkg::LINES_PER_BLOCK) ?
              16'(rpcf_pkg::LINES_PER_BLOCK) : lines_left;
        emit(rpcf_pkg::BYTE_GS); emit(rpcf_pkg::BYTE_V);
        emit(rpcf_pkg::BYTE_ZERO_CH); emit(rpcf_pkg::BYTE_NUL);
        emit(width[7:0]); emit(width[15:8]); emit(blk[7:0]); emit(blk[15:8]);
      end
      emit((px == rpcf_pkg::BYTE_LF) ? rpcf_pkg::BYTE_LF_SUB : px);
      if ({1'b0, column_count} + 17'd1 >= {1'b0, width}) begin
        column_count = '0;
        line_in_block = line_in_block + 16'd1;
        if (lines_left != 16'd0) begin
          lines_left = lines_left - 16'd1;
        end
        if (lines_left == 16'd0) begin
          line_in_block = '0;
          ended = 1'b1;
        end else if (line_in_block >= rpcf_pkg::LINES_PER_BLOCK) begin
          line_in_block = '0;
        end
      end else begin
        column_count = column_count + 16'd1;
      end
      if (ended) begin
        emit(rpcf_pkg::BYTE_US); emit(rpcf_pkg::BYTE_END_CMD);
        emit(rpcf_pkg::BYTE_END_A); emit(rpcf_pkg::BYTE_NUL);
        emit(rpcf_pkg::BYTE_US); emit(rpcf_pkg::BYTE_END_CMD);
        emit(rpcf_pkg::BYTE_END_B); emit(rpcf_pkg::BYTE_NUL);
        job_active = 1'b0;
      end
      tail = stream_q.pop_back();
      tail.last_of_run = 1'b1;
      tail.job_end = ended;
      stream_q.push_back(tail);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endtask

    task check_byte(logic [7:0] data, logic last, logic jend);
      cmd_byte_t want;
      if (stream_q.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing expected", data));
      end else begin
        want = stream_q.pop_front();
        if (data !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
        end
        if (last !== want.last_of_run) begin
          report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                    last, want.last_of_run, want.data));
        end
        if (jend !== want.job_end) begin
          report_mismatch($sformatf("job_end %b, expected %b on byte %02h",
                                    jend, want.job_end, want.data));
        end
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rpcf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rpcf_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                              idle_on;
  int unsigned                     items_sent;
  int unsigned                     quiet_cycles = 0;
  framer_scoreboard                sb = new();

  rpcf_in_if  pix_ch ();
  rpcf_out_if cmd_ch ();

  raster_print_command_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (cmd_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    cmd_ch.ready = !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      sb.check_byte(cmd_ch.out_byte, cmd_ch.last_of_run, cmd_ch.job_end);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(pix_ch.valid && pix_ch.ready) && !(cmd_ch.valid && cmd_ch.ready)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] px);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_ch.valid = 1'b0;
      @(negedge clk);
    end
    pix_ch.valid = 1'b1;
    pix_ch.pixel_byte = px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    sb.note_pixel(px);
    items_sent++;
  endtask

  // Stops the input side and waits until every predicted byte has come out.
  task automatic wait_idle();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (sb.stream_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [rpcf_pkg::CFG_IDX_W-1:0] idx,
                           logic [rpcf_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    sb.apply_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Upper data bits of the 8-bit registers carry noise that the block must drop.
  task automatic program_regs(logic [15:0] width, logic [15:0] lines, logic [7:0] speed,
                              logic [7:0] density, logic [7:0] media, int unsigned keep_pct);
    if ($urandom_range(0, 99) < keep_pct) write_reg(rpcf_pkg::CFG_LINE_WIDTH, width);
    if ($urandom_range(0, 99) < keep_pct) write_reg(rpcf_pkg::CFG_TOTAL_LINES, lines);
    if ($urandom_range(0, 99) < keep_pct) begin
      write_reg(rpcf_pkg::CFG_PRINT_SPEED, {8'($urandom), speed});
    end
    if ($urandom_range(0, 99) < keep_pct) begin
      write_reg(rpcf_pkg::CFG_PRINT_DENS, {8'($urandom), density});
    end
    if ($urandom_range(0, 99) < keep_pct) begin
      write_reg(rpcf_pkg::CFG_MEDIA_TYPE, {8'($urandom), media});
    end
  endtask

  // Closes an open job quickly: with one byte per line each byte finishes a line.
  task automatic finish_job();
    if (sb.job_active) begin
      wait_idle();
      write_reg(rpcf_pkg::CFG_LINE_WIDTH, 16'd1);
      while (sb.job_active) send_pixel(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned width;
    int unsigned lines;
    int unsigned n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_byte = '0;
    idle_on = 1'b1;
    items_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values give one-byte, one-line jobs: every byte carries prologue and trailer.
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(rpcf_pkg::BYTE_LF);
    wait_idle();

    // Zero width and zero line count must both behave as one, in the header as well.
    program_regs(16'd0, 16'd0, 8'hFF, 8'h00, 8'hAA, 100);
    send_pixel(8'h55);
    send_pixel(rpcf_pkg::BYTE_LF);
    wait_idle();

    program_regs(16'd3, 16'd2, 8'h55, 8'hFF, 8'hFF, 100);
    send_pixel(rpcf_pkg::BYTE_LF);
    send_pixel(8'h01);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(rpcf_pkg::BYTE_LF);
    send_pixel(8'hFE);
    send_pixel(8'h3C);
    wait_idle();

    // Narrowing the line mid-job ends the current line on the next byte.
    write_reg(rpcf_pkg::CFG_LINE_WIDTH, 16'd1);
    send_pixel(8'hC3);
    send_pixel(8'h0B);

    // A job longer than one block needs a second header; the first half runs without stalls.
    finish_job();
    wait_idle();
    lines = $urandom_range(241, 260);
    program_regs(16'd1, 16'(lines), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 100);
    idle_on = 1'b0;
    for (int i = 0; i < lines; i++) begin
      if (i == lines / 2) idle_on = 1'b1;
      send_pixel(8'($urandom_range(0, 255)));
    end

    // Mostly complete jobs; some are cut short and then reprogrammed while still open.
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: width = 0;
        1: width = $urandom_range(5, 65535);
        default: width = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        0: lines = 0;
        1: lines = $urandom_range(6, 30);
        default: lines = $urandom_range(1, 5);
      endcase
      program_regs(16'(width), 16'(lines), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 70);
      n = sb.bytes_to_job_end();
      if ($urandom_range(0, 99) < 20) n = $urandom_range(1, n);
      if (n > RUN_CAP) n = RUN_CAP;
      repeat (n) send_pixel(8'($urandom_range(0, 255)));
    end

    // Widest line and longest job; this last job is left open.
    finish_job();
    wait_idle();
    program_regs(16'hFFFF, 16'hFFFF, 8'h00, 8'hFF, 8'h00, 100);
    repeat (4) send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.stream_q.size() != 0) begin
      sb.report_mismatch("expected bytes never arrived");
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
